// File: src/baer_pkg.sv
// ----------------------------------------------------------------------------
// baer_pkg
// Shared types and constants for the bump allocator with exact-size reuse.
// ----------------------------------------------------------------------------
package baer_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam logic [31:0] ARENA_SIZE_RST   = 32'd268435456;
	localparam logic [31:0] START_OFFSET_RST = 32'd40960;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_OVERFLOW = 3'd2,
		STS_NOTFOUND = 3'd3,
		STS_DOUBLE   = 3'd4,
		STS_NULLQ    = 3'd5,
		STS_ZERO     = 3'd6
	} status_t;

	typedef enum logic {
		REG_ARENA_SIZE   = 1'b0,
		REG_START_OFFSET = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic        reused;
		logic        in_use;
		logic [30:0] size;
		logic [31:0] offset;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [31:0] arena_size;
		logic [31:0] start_offset;
	} cfg_t;

endpackage

// File: src/baer_ram.sv
// ----------------------------------------------------------------------------
// baer_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module baer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/baer_ctrl.sv
// ----------------------------------------------------------------------------
// baer_ctrl
// Request sequencer: scans the allocation table one entry per cycle, then decides the
// result and writes back the chosen entry on a successful allocate or a found release.
// ----------------------------------------------------------------------------
module baer_ctrl import baer_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [30:0]        num_bytes,
	input  logic [31:0]        address,
	output logic               done,
	output logic [31:0]        address_out,
	output logic [30:0]        size_out,
	output logic               reused,
	output logic [2:0]         status,
	output logic               mem_we,
	output logic [IDX_W-1:0]   mem_waddr,
	output logic [ENTRY_W-1:0] mem_wdata,
	output logic               mem_re,
	output logic [IDX_W-1:0]   mem_raddr,
	input  logic [ENTRY_W-1:0] mem_rdata
);

	state_t           state_q, state_d;
	op_t              op_q;
	logic [30:0]      nb_q;
	logic [31:0]      addr_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      next_free_q;
	logic             started_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             issued_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_entry_q;

	logic             done_q;
	logic [31:0]      address_out_q;
	logic [30:0]      size_out_q;
	logic             reused_q;
	status_t          status_q;

	op_t              op_in;
	logic             immediate;
	status_t          imm_status;
	entry_t           rentry;
	logic             more;
	logic             match;
	logic [31:0]      fin_off;
	logic [32:0]      fin_sum;
	logic             fin_ovf;
	logic             fin_full;
	logic             alloc_ok;
	logic [31:0]      res_addr;
	logic [30:0]      res_size;
	logic             res_reused;
	status_t          res_status;
	entry_t           wentry;

	assign op_in  = op_t'(op);
	assign rentry = entry_t'(mem_rdata);
	// Valid entries always form a prefix of the table, so the fill count marks them.
	assign more   = rd_idx_q < fill_q;
	assign match  = issued_s1 && ((op_q == OP_ALLOC) ?
		(!rentry.in_use && rentry.size == nb_q) : (rentry.offset == addr_q));

	always_comb begin
		immediate  = 1'b0;
		imm_status = STS_OK;
		case (op_in)
			OP_ALLOC: begin
				immediate  = (num_bytes == 31'd0);
				imm_status = STS_ZERO;
			end
			OP_RELEASE: begin
				immediate = (address == 32'd0);
			end
			OP_QUERY: begin
				immediate  = (address == 32'd0);
				imm_status = STS_NULLQ;
			end
			default: begin
				immediate = 1'b1;
			end
		endcase
	end

	// Decision for the finishing cycle.
	always_comb begin
		fin_off    = hit_q ? hit_entry_q.offset : next_free_q;
		fin_sum    = {1'b0, fin_off} + {2'b00, nb_q};
		fin_ovf    = fin_sum >= {1'b0, cfg.arena_size};
		fin_full   = !hit_q && (fill_q == CNT_W'(TABLE_ENTRIES));
		alloc_ok   = 1'b0;
		res_addr   = addr_q;
		res_size   = 31'd0;
		res_reused = 1'b0;
		res_status = STS_OK;
		wentry     = hit_entry_q;
		case (op_q)
			OP_ALLOC: begin
				res_addr = 32'd0;
				if (fin_full) begin
					res_status = STS_FULL;
				end else if (fin_ovf) begin
					res_status = STS_OVERFLOW;
				end else begin
					alloc_ok   = 1'b1;
					res_addr   = fin_off;
					res_size   = nb_q;
					res_reused = hit_q;
				end
				wentry.reused = hit_q;
				wentry.in_use = 1'b1;
				wentry.size   = nb_q;
				wentry.offset = fin_off;
			end
			OP_RELEASE, OP_QUERY: begin
				if (!hit_q) begin
					res_status = STS_NOTFOUND;
				end else begin
					res_size = hit_entry_q.size;
					if (op_q == OP_RELEASE && !hit_entry_q.in_use) begin
						res_status = STS_DOUBLE;
					end
				end
				wentry.in_use = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = hit_q ? hit_idx_q : fill_q[IDX_W-1:0];
		mem_wdata = wentry;
		case (state_q)
			S_IDLE: begin
				if (start && !immediate) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				mem_re = more && !match;
				if (match || !more) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				mem_we  = alloc_ok || (op_q == OP_RELEASE && hit_q);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
		end else begin
			state_q     <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			next_free_q <= '0;
			started_q   <= 1'b0;
			rd_idx_q    <= '0;
			issued_s1   <= 1'b0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_idx_q  <= '0;
						issued_s1 <= 1'b0;
						hit_q     <= 1'b0;
						done_q    <= immediate;
						// The arena opens on the first allocate of a nonzero size.
						if (op_in == OP_ALLOC && num_bytes != 31'd0 && !started_q) begin
							next_free_q <= cfg.start_offset;
							started_q   <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					issued_s1 <= mem_re;
					if (mem_re) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (match) begin
						hit_q <= 1'b1;
					end
				end
				S_FINISH: begin
					done_q <= 1'b1;
					if (alloc_ok && !hit_q) begin
						fill_q      <= fill_q + CNT_W'(1);
						next_free_q <= fin_sum[31:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q          <= op_in;
					nb_q          <= num_bytes;
					addr_q        <= address;
					address_out_q <= (op_in == OP_ALLOC) ? 32'd0 : address;
					size_out_q    <= 31'd0;
					reused_q      <= 1'b0;
					status_q      <= imm_status;
				end
			end
			S_SCAN: begin
				idx_s1 <= rd_idx_q[IDX_W-1:0];
				if (match) begin
					hit_idx_q   <= idx_s1;
					hit_entry_q <= rentry;
				end
			end
			S_FINISH: begin
				address_out_q <= res_addr;
				size_out_q    <= res_size;
				reused_q      <= res_reused;
				status_q      <= res_status;
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign address_out = address_out_q;
	assign size_out    = size_out_q;
	assign reused      = reused_q;
	assign status      = status_q;

endmodule

// File: src/bump_allocator_exact_reuse_unit.sv
// ----------------------------------------------------------------------------
// bump_allocator_exact_reuse_unit
// Arena allocator with a 512-entry allocation table and exact-size reuse.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result beat
// appears on the result ports with done high for exactly one cycle and must be
// captured then, since the block cannot be held off. Requests that need no
// table lookup (allocate of zero bytes, release or query of the null offset,
// and the unused op code) answer in the cycle after acceptance. Any other
// request scans the table RAM one entry per cycle through its single read
// port. Released entries are scanned as well, and the scan stops early when
// an entry matches, so every entry ever written may be read before the result.
// Busy falls in the cycle of the result beat, and a new request may start
// there. Configuration writes must be made while busy is low.
module bump_allocator_exact_reuse_unit import baer_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [30:0] num_bytes,
	input  logic [31:0] address,
	output logic        done,
	output logic [31:0] address_out,
	output logic [30:0] size_out,
	output logic        reused,
	output logic [2:0]  status
);

	cfg_t               cfg_q;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arena_size   <= ARENA_SIZE_RST;
			cfg_q.start_offset <= START_OFFSET_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ARENA_SIZE: begin
					cfg_q.arena_size <= cfg_data;
				end
				REG_START_OFFSET: begin
					cfg_q.start_offset <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	baer_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.num_bytes   (num_bytes),
		.address     (address),
		.done        (done),
		.address_out (address_out),
		.size_out    (size_out),
		.reused      (reused),
		.status      (status),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	baer_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
